// File: hw/rtl/scm_pkg.sv
// Shared types, stage map and helper function of the support cone merge point.
package scm_pkg;

  // Beat types of the two channels
  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] merge_x;
    logic signed [31:0] merge_y;
    logic signed [31:0] merge_z;
  } out_t;

  // Register
  localparam int unsigned CritW = 17;
  localparam logic [CritW-1:0] CRIT_RESET = 17'd32768;
  localparam logic [CritW-1:0] CRIT_ONE   = 17'd65536;

  // Arithmetic units
  localparam int unsigned SQ_STEPS  = 32;  // one root bit per stage
  localparam int unsigned DIV_STEPS = 63;  // one quotient bit per stage
  localparam int unsigned SQ_LAT    = SQ_STEPS;
  localparam int unsigned MD_LAT    = DIV_STEPS + 3;
  localparam logic [31:0] TRIG_ONE_B = 32'd1 << 30;
  localparam logic [62:0] DIV_CAP    = 63'd1 << 62;
  localparam logic [62:0] OFF_CAP    = 63'd1 << 40;

  // Stage map of the main pipe
  localparam int unsigned ST_U     = 4;                 // squares ready
  localparam int unsigned ST_HS    = ST_U + SQ_LAT;     // horizontal length out
  localparam int unsigned ST_S     = ST_U + MD_LAT;     // squared sine out
  localparam int unsigned ST_T     = ST_S + 1;          // ray sines clamped
  localparam int unsigned ST_TO    = ST_T + SQ_LAT;     // trig roots out
  localparam int unsigned ST_P     = ST_TO + 1;         // roots in pipe
  localparam int unsigned ST_N     = ST_P + 2;          // num and den ready
  localparam int unsigned ST_LO    = ST_N + MD_LAT;     // travel out
  localparam int unsigned ST_O     = ST_LO + 1;
  localparam int unsigned ST_OO    = ST_O + MD_LAT;     // xy split out
  localparam int unsigned ST_F     = ST_OO + 1;
  localparam int unsigned DEPTH    = ST_F + 2;

  // Everything one item carries down the pipe
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic        sh;
    logic        negx;
    logic        negy;
    logic        dzneg;
    logic        dzpos;
    logic        xyzero;
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] pz;
    logic [63:0] h2;
    logic [63:0] dsum;
    logic [31:0] hs;
    logic [30:0] sa;
    logic [30:0] sb;
    logic [30:0] sna;
    logic [30:0] ca;
    logic [30:0] snb;
    logic [30:0] cb;
    logic [61:0] m1;
    logic [61:0] m2;
    logic [62:0] p;
    logic [62:0] q;
    logic [62:0] den;
    logic        denz;
    logic [63:0] num;
    logic        nf;
    logic [62:0] lval;
    logic [62:0] offz;
    logic [62:0] offx;
    logic [62:0] offy;
    out_t        res;
  } stage_t;

  // Offset capped, rescaled, applied to a base and saturated to 32 bits
  function automatic logic [31:0] place_coord(logic signed [31:0] base, logic [62:0] off,
                                              logic neg, logic sh);
    logic [40:0]        offc;
    logic signed [43:0] offs;
    logic signed [43:0] bse;
    logic signed [43:0] v;
    offc = (off > OFF_CAP) ? OFF_CAP[40:0] : off[40:0];
    offs = sh ? $signed({2'b00, offc, 1'b0}) : $signed({3'b000, offc});
    bse  = $signed({{12{base[31]}}, base});
    v    = neg ? (bse - offs) : (bse + offs);
    if (v > 44'sd2147483647) begin
      place_coord = 32'h7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      place_coord = 32'h8000_0000;
    end else begin
      place_coord = v[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/support_cone_merge_point.sv
// Support cone merge point: intersects the two critical-angle rays below points A and B.
// One point pair enters per clock while the output is not held; the depth of the pipe is
// set by the chain of one-bit-per-stage units: a 63-step divider for the squared sine,
// 32-step square roots for the horizontal length and the ray sines and cosines, and two
// more 63-step dividers in series for the ray travel and its split onto x and y. A stall
// at the output holds the whole pipe, nothing is dropped. The critical squared sine
// register may only be written while no item is in flight.
module support_cone_merge_point (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              crit_we_i,
  input  logic [scm_pkg::CritW-1:0]         crit_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  scm_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output scm_pkg::out_t                     out_data_o
);
  import scm_pkg::*;

  logic [CritW-1:0] crit_q;
  logic [CritW-1:0] crit_eff;
  logic [30:0]      crit_c;
  logic             en;
  logic             v_q [DEPTH];
  stage_t           pipe_q [DEPTH];
  stage_t           nxt_d [DEPTH];

  logic [31:0] hs_w, sna_w, ca_w, snb_w, cb_w;
  logic [62:0] s_w, l_w, oz_w, ox_w, oy_w;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= CRIT_RESET;
    end else if (crit_we_i) begin
      crit_q <= crit_wdata_i;
    end
  end

  assign crit_eff = (crit_q > CRIT_ONE) ? CRIT_ONE : crit_q;
  assign crit_c   = {crit_eff, 14'd0};

  // Global advance: the pipe moves unless the output beat is held
  assign en          = !v_q[DEPTH-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[DEPTH-1];
  assign out_data_o  = pipe_q[DEPTH-1].res;

  // Arithmetic units
  scm_isqrt u_sq_hs (.clk_i, .en_i(en), .x_i(pipe_q[ST_U].h2), .r_o(hs_w));

  scm_muldiv u_md_s (.clk_i, .en_i(en), .a_i(pipe_q[ST_U].pz), .b_i(TRIG_ONE_B),
                     .d_i(pipe_q[ST_U].dsum), .q_o(s_w));

  scm_isqrt u_sq_sna (.clk_i, .en_i(en), .x_i({3'd0, pipe_q[ST_T].sa, 30'd0}), .r_o(sna_w));
  scm_isqrt u_sq_ca  (.clk_i, .en_i(en),
                      .x_i({3'd0, 31'(TRIG_ONE_B) - pipe_q[ST_T].sa, 30'd0}), .r_o(ca_w));
  scm_isqrt u_sq_snb (.clk_i, .en_i(en), .x_i({3'd0, pipe_q[ST_T].sb, 30'd0}), .r_o(snb_w));
  scm_isqrt u_sq_cb  (.clk_i, .en_i(en),
                      .x_i({3'd0, 31'(TRIG_ONE_B) - pipe_q[ST_T].sb, 30'd0}), .r_o(cb_w));

  scm_muldiv u_md_l (.clk_i, .en_i(en), .a_i(pipe_q[ST_N].num),
                     .b_i({1'b0, pipe_q[ST_N].ca}), .d_i({1'b0, pipe_q[ST_N].den}),
                     .q_o(l_w));
  scm_muldiv u_md_z (.clk_i, .en_i(en), .a_i(pipe_q[ST_N].num),
                     .b_i({1'b0, pipe_q[ST_N].sna}), .d_i({1'b0, pipe_q[ST_N].den}),
                     .q_o(oz_w));

  scm_muldiv u_md_x (.clk_i, .en_i(en), .a_i({1'b0, pipe_q[ST_O].lval}),
                     .b_i(pipe_q[ST_O].ux), .d_i({32'd0, pipe_q[ST_O].hs}), .q_o(ox_w));
  scm_muldiv u_md_y (.clk_i, .en_i(en), .a_i({1'b0, pipe_q[ST_O].lval}),
                     .b_i(pipe_q[ST_O].uy), .d_i({32'd0, pipe_q[ST_O].hs}), .q_o(oy_w));

  // Stage logic
  always_comb begin
    logic [32:0] mx, my, mz;
    logic [30:0] sv;
    logic [62:0] densum;
    nxt_d[0] = '0;
    nxt_d[0].ax = in_data_i.a_x;
    nxt_d[0].ay = in_data_i.a_y;
    nxt_d[0].az = in_data_i.a_z;
    nxt_d[0].bx = in_data_i.b_x;
    nxt_d[0].by = in_data_i.b_y;
    nxt_d[0].bz = in_data_i.b_z;
    for (int k = 1; k < DEPTH; k++) begin
      nxt_d[k] = pipe_q[k-1];
    end

    // differences
    nxt_d[1].dx = $signed({pipe_q[0].bx[31], pipe_q[0].bx})
                - $signed({pipe_q[0].ax[31], pipe_q[0].ax});
    nxt_d[1].dy = $signed({pipe_q[0].by[31], pipe_q[0].by})
                - $signed({pipe_q[0].ay[31], pipe_q[0].ay});
    nxt_d[1].dz = $signed({pipe_q[0].bz[31], pipe_q[0].bz})
                - $signed({pipe_q[0].az[31], pipe_q[0].az});

    // magnitudes, halved when any reaches 2^31
    mx = pipe_q[1].dx[32] ? 33'(-pipe_q[1].dx) : pipe_q[1].dx;
    my = pipe_q[1].dy[32] ? 33'(-pipe_q[1].dy) : pipe_q[1].dy;
    mz = pipe_q[1].dz[32] ? 33'(-pipe_q[1].dz) : pipe_q[1].dz;
    nxt_d[2].sh = |{mx[32:31], my[32:31], mz[32:31]};
    nxt_d[2].ux = nxt_d[2].sh ? mx[32:1] : mx[31:0];
    nxt_d[2].uy = nxt_d[2].sh ? my[32:1] : my[31:0];
    nxt_d[2].uz = nxt_d[2].sh ? mz[32:1] : mz[31:0];
    nxt_d[2].negx   = pipe_q[1].dx[32];
    nxt_d[2].negy   = pipe_q[1].dy[32];
    nxt_d[2].dzneg  = pipe_q[1].dz[32];
    nxt_d[2].dzpos  = !pipe_q[1].dz[32] && (pipe_q[1].dz != '0);
    nxt_d[2].xyzero = (nxt_d[2].ux == '0) && (nxt_d[2].uy == '0);

    // squares
    nxt_d[3].px = 64'(pipe_q[2].ux) * 64'(pipe_q[2].ux);
    nxt_d[3].py = 64'(pipe_q[2].uy) * 64'(pipe_q[2].uy);
    nxt_d[3].pz = 64'(pipe_q[2].uz) * 64'(pipe_q[2].uz);

    nxt_d[4].h2   = pipe_q[3].px + pipe_q[3].py;
    nxt_d[4].dsum = pipe_q[3].px + pipe_q[3].py + pipe_q[3].pz;

    nxt_d[ST_HS+1].hs = hs_w;

    // ray squared sines, never flatter than the critical angle
    sv = s_w[30:0];
    nxt_d[ST_T].sa = (pipe_q[ST_S].dzneg && (sv > crit_c)) ? sv : crit_c;
    nxt_d[ST_T].sb = (pipe_q[ST_S].dzpos && (sv > crit_c)) ? sv : crit_c;

    nxt_d[ST_P].sna = sna_w[30:0];
    nxt_d[ST_P].ca  = ca_w[30:0];
    nxt_d[ST_P].snb = snb_w[30:0];
    nxt_d[ST_P].cb  = cb_w[30:0];

    // cross products
    nxt_d[ST_P+1].m1 = 62'(pipe_q[ST_P].ca) * 62'(pipe_q[ST_P].snb);
    nxt_d[ST_P+1].m2 = 62'(pipe_q[ST_P].sna) * 62'(pipe_q[ST_P].cb);
    nxt_d[ST_P+1].p  = 63'(pipe_q[ST_P].snb) * 63'(pipe_q[ST_P].hs);
    nxt_d[ST_P+1].q  = 63'(pipe_q[ST_P].uz) * 63'(pipe_q[ST_P].cb);

    // numerator and denominator of the ray parameter
    densum = 63'(pipe_q[ST_N-1].m1) + 63'(pipe_q[ST_N-1].m2);
    nxt_d[ST_N].den  = densum;
    nxt_d[ST_N].denz = (densum == '0);
    nxt_d[ST_N].nf   = pipe_q[ST_N-1].dzpos && (pipe_q[ST_N-1].p < pipe_q[ST_N-1].q);
    if (pipe_q[ST_N-1].dzpos) begin
      nxt_d[ST_N].num = 64'(pipe_q[ST_N-1].p - pipe_q[ST_N-1].q);
    end else if (pipe_q[ST_N-1].dzneg) begin
      nxt_d[ST_N].num = 64'(pipe_q[ST_N-1].p) + 64'(pipe_q[ST_N-1].q);
    end else begin
      nxt_d[ST_N].num = 64'(pipe_q[ST_N-1].p);
    end

    nxt_d[ST_O].lval = l_w;
    nxt_d[ST_O].offz = oz_w;
    nxt_d[ST_F].offx = ox_w;
    nxt_d[ST_F].offy = oy_w;

    // place the merge point
    nxt_d[ST_F+1].res.found = !pipe_q[ST_F].xyzero && !pipe_q[ST_F].denz
                            && !pipe_q[ST_F].nf;
    if (nxt_d[ST_F+1].res.found) begin
      nxt_d[ST_F+1].res.merge_x = place_coord(pipe_q[ST_F].ax, pipe_q[ST_F].offx,
                                              pipe_q[ST_F].negx, pipe_q[ST_F].sh);
      nxt_d[ST_F+1].res.merge_y = place_coord(pipe_q[ST_F].ay, pipe_q[ST_F].offy,
                                              pipe_q[ST_F].negy, pipe_q[ST_F].sh);
      nxt_d[ST_F+1].res.merge_z = place_coord(pipe_q[ST_F].az, pipe_q[ST_F].offz,
                                              1'b1, pipe_q[ST_F].sh);
    end else begin
      nxt_d[ST_F+1].res.merge_x = '0;
      nxt_d[ST_F+1].res.merge_y = '0;
      nxt_d[ST_F+1].res.merge_z = '0;
    end
  end

  // Pipe payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < DEPTH; k++) begin
        pipe_q[k] <= nxt_d[k];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < DEPTH; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_when_missed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.merge_x == '0 && out_data_o.merge_y == '0 && out_data_o.merge_z == '0)
    else $error("merge fields not cleared on a miss");

  a_not_above_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.merge_z <= pipe_q[DEPTH-1].az)
    else $error("merge point above first point");

  a_hs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_F] && !pipe_q[ST_F].xyzero |-> pipe_q[ST_F].hs != '0)
    else $error("zero horizontal length with xy separation");

  a_beat_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[DEPTH-2] |=> out_valid_o)
    else $error("beat lost before the output stage");
`endif

endmodule

// File: hw/rtl/scm_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
module scm_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] r_o
);
  import scm_pkg::*;

  logic [63:0] x_q [SQ_STEPS];
  logic [63:0] r_q [SQ_STEPS];
  logic [63:0] x_d [SQ_STEPS];
  logic [63:0] r_d [SQ_STEPS];

  // Digit recurrence, bit weight 4^(31-j) at stage j
  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      logic [63:0] xp;
      logic [63:0] rp;
      logic [63:0] bw;
      logic [63:0] t;
      xp = (j == 0) ? x_i : x_q[(j == 0) ? 0 : j-1];
      rp = (j == 0) ? 64'd0 : r_q[(j == 0) ? 0 : j-1];
      bw = 64'd1 << (62 - 2*j);
      t  = rp + bw;
      if (xp >= t) begin
        x_d[j] = xp - t;
        r_d[j] = (rp >> 1) + bw;
      end else begin
        x_d[j] = xp;
        r_d[j] = rp >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQ_STEPS; j++) begin
        x_q[j] <= x_d[j];
        r_q[j] <= r_d[j];
      end
    end
  end

  assign r_o = r_q[SQ_STEPS-1][31:0];

endmodule

// File: hw/rtl/scm_muldiv.sv
// Pipelined floor(a*b/d) with the quotient capped at 2^62 once it reaches 2^63.
module scm_muldiv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [31:0] b_i,
  input  logic [63:0] d_i,
  output logic [62:0] q_o
);
  import scm_pkg::*;

  logic [63:0] pl_q, ph_q, d1_q, d2_q;
  logic [95:0] n_q;

  // Stage 0 is the overflow check, stages 1..DIV_STEPS make one bit each
  logic [63:0] rem_q [DIV_STEPS+1];
  logic [62:0] nlo_q [DIV_STEPS+1];
  logic [62:0] qt_q  [DIV_STEPS+1];
  logic [63:0] dd_q  [DIV_STEPS+1];
  logic        ovf_q [DIV_STEPS+1];
  logic [63:0] rem_d [DIV_STEPS+1];
  logic [62:0] qt_d  [DIV_STEPS+1];

  // Restoring division steps
  always_comb begin
    rem_d[0] = {31'd0, n_q[95:63]};
    qt_d[0]  = '0;
    for (int j = 1; j <= DIV_STEPS; j++) begin
      logic [64:0] remx;
      remx = {rem_q[j-1], nlo_q[j-1][62]};
      if (remx >= {1'b0, dd_q[j-1]}) begin
        rem_d[j] = 64'(remx - {1'b0, dd_q[j-1]});
        qt_d[j]  = {qt_q[j-1][61:0], 1'b1};
      end else begin
        rem_d[j] = remx[63:0];
        qt_d[j]  = {qt_q[j-1][61:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products, then their sum
      pl_q <= 64'(a_i[31:0]) * 64'(b_i);
      ph_q <= 64'(a_i[63:32]) * 64'(b_i);
      d1_q <= d_i;
      n_q  <= {ph_q, 32'd0} + {32'd0, pl_q};
      d2_q <= d1_q;
      rem_q[0] <= rem_d[0];
      nlo_q[0] <= n_q[62:0];
      qt_q[0]  <= qt_d[0];
      dd_q[0]  <= d2_q;
      ovf_q[0] <= {31'd0, n_q[95:63]} >= d2_q;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        rem_q[j] <= rem_d[j];
        nlo_q[j] <= {nlo_q[j-1][61:0], 1'b0};
        qt_q[j]  <= qt_d[j];
        dd_q[j]  <= dd_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign q_o = ovf_q[DIV_STEPS] ? DIV_CAP : qt_q[DIV_STEPS];

endmodule

// File: sim/tb_support_cone_merge_point.sv
// Testbench of the support cone merge point: random and directed point pairs, scoreboarded.
module tb_support_cone_merge_point;
  timeunit 1ns;
  timeprecision 1ps;
  import scm_pkg::*;

  localparam int unsigned PIPE_LAT = 242;

  logic              clk_i;
  logic              rst_ni;
  logic              crit_we_i;
  logic [CritW-1:0]  crit_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_t               in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_t              out_data_o;

  support_cone_merge_point i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .crit_we_i   (crit_we_i),
    .crit_wdata_i(crit_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  in_t              pending_pairs[$];
  out_t             merge_expected[$];
  logic [CritW-1:0] crit_shadow;
  int               err_cnt;
  bit               idle_on;
  bit               stall_req;

  // Clock
  always begin
    clk_i = 1'b1;
    #10ns;
    clk_i = 1'b0;
    #10ns;
  end

  // Floor square root
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= {64'd0, x}) r = t;
    end
    return r[63:0];
  endfunction

  // a*b/d truncated, capped at 2^62 once the quotient reaches 2^63
  function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] quo;
    quo = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    if (quo >= (128'd1 << 63)) return 64'd1 << 62;
    return quo[63:0];
  endfunction

  // Offset onto a base coordinate, saturated to 32 bits
  function automatic logic [31:0] shift_coord(longint base, logic [63:0] off, bit neg, bit s);
    longint v;
    if (off > (64'd1 << 40)) off = 64'd1 << 40;
    off = off << s;
    v = neg ? base - longint'(off) : base + longint'(off);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Expected merge point of one pair under a given critical squared sine
  function automatic out_t merge_point(in_t b, logic [CritW-1:0] crit_reg);
    out_t        r;
    longint      ax, ay, az, dx, dy, dz;
    logic [63:0] ux, uy, uz, mx, h2, hs, z2, dsum, rem, sq;
    logic [63:0] c, sa, sb, sna, ca, snb, cb, den, p, q, num, lt, ox, oy, oz;
    logic [16:0] crit;
    bit          s, carry;
    r = '0;
    ax = b.a_x; ay = b.a_y; az = b.a_z;
    dx = longint'(b.b_x) - ax;
    dy = longint'(b.b_y) - ay;
    dz = longint'(b.b_z) - az;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    uz = dz < 0 ? -dz : dz;
    mx = ux > uy ? ux : uy;
    if (uz > mx) mx = uz;
    s = (mx >> 31) != 0;
    ux = ux >> s; uy = uy >> s; uz = uz >> s;
    if (ux == 0 && uy == 0) return r;
    h2 = ux * ux + uy * uy;
    hs = floor_root(h2);
    z2 = uz * uz;
    dsum = h2 + z2;
    rem = z2;
    sq = 0;
    for (int i = 0; i < 30; i++) begin
      carry = rem[63];
      rem = rem << 1;
      sq = sq << 1;
      if (carry || rem >= dsum) begin
        rem = rem - dsum;
        sq[0] = 1'b1;
      end
    end
    crit = crit_reg > CRIT_ONE ? CRIT_ONE : crit_reg;
    c = 64'(crit) << 14;
    sa = (dz < 0 && sq > c) ? sq : c;
    sb = (dz > 0 && sq > c) ? sq : c;
    sna = floor_root(sa << 30);
    ca  = floor_root(((64'd1 << 30) - sa) << 30);
    snb = floor_root(sb << 30);
    cb  = floor_root(((64'd1 << 30) - sb) << 30);
    den = ca * snb + sna * cb;
    if (den == 0) return r;
    p = snb * hs;
    q = uz * cb;
    if (dz > 0) begin
      if (p < q) return r;
      num = p - q;
    end else if (dz < 0) begin
      num = p + q;
    end else begin
      num = p;
    end
    lt = scaled_quot(num, ca, den);
    oz = scaled_quot(num, sna, den);
    ox = scaled_quot(lt, ux, hs);
    oy = scaled_quot(lt, uy, hs);
    r.found   = 1'b1;
    r.merge_x = shift_coord(ax, ox, dx < 0, s);
    r.merge_y = shift_coord(ay, oy, dy < 0, s);
    r.merge_z = shift_coord(az, oz, 1'b1, s);
    return r;
  endfunction

  // Driver: pops pending pairs, random idle bursts
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     = 0;
    end else begin
      if (in_valid_i && in_ready_o)
        merge_expected.push_back(merge_point(in_data_i, crit_shadow));
      if (in_valid_i && !in_ready_o) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 19) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, one long hold-off on request, compare beats
  int unsigned out_gap;
  int unsigned hold_left;
  out_t        exp_beat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     = 0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (merge_expected.size() == 0) begin
          $error("unexpected result beat");
          err_cnt++;
        end else begin
          exp_beat = merge_expected.pop_front();
          if (out_data_o.found !== exp_beat.found) begin
            $error("found: expected %0d actual %0d", exp_beat.found, out_data_o.found);
            err_cnt++;
          end
          if (out_data_o.merge_x !== exp_beat.merge_x) begin
            $error("merge_x: expected %0d actual %0d", exp_beat.merge_x, out_data_o.merge_x);
            err_cnt++;
          end
          if (out_data_o.merge_y !== exp_beat.merge_y) begin
            $error("merge_y: expected %0d actual %0d", exp_beat.merge_y, out_data_o.merge_y);
            err_cnt++;
          end
          if (out_data_o.merge_z !== exp_beat.merge_z) begin
            $error("merge_z: expected %0d actual %0d", exp_beat.merge_z, out_data_o.merge_z);
            err_cnt++;
          end
        end
      end
      if (stall_req && hold_left == 0) begin
        stall_req = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_t make_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    in_t t;
    t.a_x = ax; t.a_y = ay; t.a_z = az;
    t.b_x = bx; t.b_y = by; t.b_z = bz;
    return t;
  endfunction

  // Random pair: half nearby points, the rest fully random, coincident in XY or level
  function automatic in_t random_pair();
    in_t         t;
    int unsigned kind;
    int unsigned span;
    kind = $urandom_range(0, 9);
    t = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind < 5) begin
      span = $urandom_range(4, 24);
      t.b_x = t.a_x + $signed($urandom_range(0, 2 << span)) - (1 <<< span);
      t.b_y = t.a_y + $signed($urandom_range(0, 2 << span)) - (1 <<< span);
      t.b_z = t.a_z + $signed($urandom_range(0, 2 << span)) - (1 <<< span);
    end else if (kind == 7) begin
      t.b_x = t.a_x;
      t.b_y = t.a_y;
    end else if (kind == 8) begin
      t.b_z = t.a_z;
    end
    return t;
  endfunction

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid_i || merge_expected.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_crit(logic [CritW-1:0] v);
    @(posedge clk_i);
    crit_we_i    <= 1'b1;
    crit_wdata_i <= v;
    crit_shadow   = v;
    @(posedge clk_i);
    crit_we_i    <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    repeat (n) pending_pairs.push_back(random_pair());
    drain();
  endtask

  // Stimulus
  initial begin
    crit_we_i    = 1'b0;
    crit_wdata_i = '0;
    crit_shadow  = CRIT_RESET;
    err_cnt      = 0;
    idle_on      = 1'b1;
    stall_req    = 1'b0;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, coincident XY, level, steep, behind, one-unit offsets
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_pairs.push_back(make_pair(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(0, 0, 32'h7FFF_FFFF, 1, 0, 32'h8000_0000));
    pending_pairs.push_back(make_pair(32'h8000_0000, 5, 0, 32'h7FFF_FFFF, 6, 0));
    pending_pairs.push_back(make_pair(100, 200, 300, 100, 200, 900));
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h0001_0000, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_0000));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 32'h0100_0000));
    pending_pairs.push_back(make_pair(0, 0, 32'h0100_0000, 1, 0, 0));
    pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0));
    pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFE, 0, 32'h8000_0000));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 1));
    pending_pairs.push_back(make_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                                      32'h1234_5678, 32'h9ABC_DEF0, 32'hF0F0_F0F0));
    drain();

    // register extremes and settings above one
    write_crit(17'd0);
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h0001_0000, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000));
    random_phase(50);
    write_crit(CRIT_ONE);
    pending_pairs.push_back(make_pair(0, 0, 0, 32'h0001_0000, 0, 32'h0002_0000));
    random_phase(50);
    write_crit(17'h1FFFF);
    random_phase(30);
    write_crit(17'd65535);
    random_phase(30);
    write_crit(17'd1);
    random_phase(30);

    // random settings, one long phase under an output hold-off that fills the pipe
    for (int k = 0; k < 5; k++) begin
      write_crit(17'($urandom_range(0, 65536)));
      if (k == 1) begin
        stall_req = 1'b1;
        random_phase(300);
      end else begin
        random_phase(19);
      end
    end

    // last part without idling
    idle_on = 1'b0;
    write_crit(17'($urandom_range(0, 65536)));
    random_phase(70);

    repeat (PIPE_LAT + 20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
